@@ rtl/core/spa_pkg.sv @@
// ---------------------------------------------------------------------------
// spa_pkg
// Shared constants and types of the spectral power accumulator.
// ---------------------------------------------------------------------------
package spa_pkg;

	// array sizes
	localparam int NUM_ANTENNAS = 16;
	localparam int NUM_COARSE   = 64;
	localparam int FFT_POINTS   = 128;
	localparam int HALF_POINTS  = FFT_POINTS / 2;
	localparam int STORE_DEPTH  = NUM_ANTENNAS * NUM_COARSE * FFT_POINTS;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int CHAN_W       = $clog2(FFT_POINTS);
	localparam int FLAG_IDX_W   = (NUM_ANTENNAS > 1) ? $clog2(NUM_ANTENNAS) : 1;

	// field widths
	localparam int ANT_W    = 4;
	localparam int COARSE_W = 6;
	localparam int BIN_W    = 7;
	localparam int CPLX_W   = 16;
	localparam int SQ_W     = 31;
	localparam int PSUM_W   = 32;
	localparam int POWER_W  = 48;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 48;

	localparam logic [POWER_W-1:0] ACC_MAX = {POWER_W{1'b1}};

	// request kinds
	localparam logic REQ_ACCUM = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	// register map
	localparam int PADDR_W = 4;
	localparam logic [1:0] REG_DUAL_SIDEBAND  = 2'd0;
	localparam logic [1:0] REG_ZAP_DC         = 2'd1;
	localparam logic [1:0] REG_ANTENNA_SELECT = 2'd2;

	// result queue
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = 2;
	localparam int OUT_CNT_W = 3;

	typedef struct packed {
		logic                    dual_sideband;
		logic                    zap_dc;
		logic signed [4:0]       antenna_select;
	} cfg_t;

	typedef struct packed {
		logic                    saturated;
		logic [POWER_W-1:0]      power;
	} out_item_t;

endpackage

@@ rtl/core/spectral_power_accumulator.sv @@
// ---------------------------------------------------------------------------
// spectral_power_accumulator
// Power detection of FFT bins and per-antenna, per-channel integration.
// ---------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata: antenna, coarse, bin, re, im
//                                        tuser: req_type (0 accum, 1 read+clear)
//  m_axis    out  tvalid/tready          tdata: power, tuser: saturated
//  apb       in   psel/penable/pready    dual_sideband @0, zap_dc @4,
//                                        antenna_select @8
//
//  One item per cycle while s_axis_tready is high; a read result reaches m_axis
//  after the steps accept, RAM read, modify/write and queue.
//  After reset the store is swept to zero, one entry per cycle, across
//  all STORE_DEPTH entries; no item is taken until the sweep ends.
//  Result stalls: s_axis_tready drops once queued plus in-flight reads
//  fill the four-entry result queue; the store pipeline never stalls.
// ---------------------------------------------------------------------------
module spectral_power_accumulator (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // antenna[3:0] coarse_chan[9:4] bin[16:10]
	                                   // re_part[32:17] im_part[48:33] zero[55:49]
	input  logic        s_axis_tuser,  // req_type
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // power[47:0]
	output logic        m_axis_tuser,  // saturated
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import spa_pkg::*;

	cfg_t cfg;

	// ---------------- post-reset clearing sweep ----------------
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + ADDR_W'(1);
			if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// ---------------- input accept ----------------
	logic                     accept;
	logic [OUT_CNT_W-1:0]     fifo_cnt;
	logic [OUT_CNT_W-1:0]     reserved;
	logic                     vld_s1;
	logic                     rd_s1;
	logic                     vld_s2;
	logic                     rd_s2;

	// reads in flight hold a queue slot each
	assign reserved = fifo_cnt + OUT_CNT_W'(vld_s1 && rd_s1) + OUT_CNT_W'(vld_s2 && rd_s2);
	assign s_axis_tready = !clearing_q && (reserved < OUT_CNT_W'(OUT_DEPTH));
	assign accept = s_axis_tvalid && s_axis_tready;

	logic signed [CPLX_W-1:0]   re_in;
	logic signed [CPLX_W-1:0]   im_in;
	logic signed [2*CPLX_W-1:0] sq_re;
	logic signed [2*CPLX_W-1:0] sq_im;

	assign re_in = s_axis_tdata[32:17];
	assign im_in = s_axis_tdata[48:33];
	assign sq_re = re_in * re_in;
	assign sq_im = im_in * im_in;

	// ---------------- stage 1: address, RAM read ----------------
	logic [ANT_W-1:0]    ant_s1;
	logic [COARSE_W-1:0] coarse_s1;
	logic [BIN_W-1:0]    bin_s1;
	logic [SQ_W-1:0]     sq_re_s1;
	logic [SQ_W-1:0]     sq_im_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			rd_s1  <= 1'b0;
		end else begin
			vld_s1 <= accept;
			rd_s1  <= (s_axis_tuser == REQ_READ);
		end
	end

	always_ff @(posedge clk) begin
		ant_s1    <= s_axis_tdata[3:0];
		coarse_s1 <= s_axis_tdata[9:4];
		bin_s1    <= s_axis_tdata[16:10];
		sq_re_s1  <= sq_re[SQ_W-1:0];
		sq_im_s1  <= sq_im[SQ_W-1:0];
	end

	logic              in_range_s1;
	logic              selected_s1;
	logic              ok_s1;
	logic [CHAN_W-1:0] chan_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [PSUM_W-1:0] pwr_s1;

	assign in_range_s1 = (32'(ant_s1) < NUM_ANTENNAS) && (32'(coarse_s1) < NUM_COARSE)
		&& (32'(bin_s1) < FFT_POINTS);
	assign selected_s1 = cfg.antenna_select[4] || (cfg.antenna_select[3:0] == ant_s1);
	assign ok_s1 = in_range_s1 && (rd_s1 || selected_s1);

	always_comb begin
		if (!rd_s1 && cfg.dual_sideband) begin
			if (32'(bin_s1) >= HALF_POINTS) begin
				chan_s1 = CHAN_W'(32'(bin_s1) - HALF_POINTS);
			end else begin
				chan_s1 = CHAN_W'(32'(bin_s1) + HALF_POINTS);
			end
		end else begin
			chan_s1 = CHAN_W'(bin_s1);
		end
	end

	assign addr_s1 = ADDR_W'((32'(ant_s1) * NUM_COARSE + 32'(coarse_s1)) * FFT_POINTS
		+ 32'(chan_s1));
	assign pwr_s1 = PSUM_W'(sq_re_s1) + PSUM_W'(sq_im_s1);

	// ---------------- stage 2: modify, write back ----------------
	logic                  ok_s2;
	logic                  dc_s2;
	logic                  zap_s2;
	logic [FLAG_IDX_W-1:0] ant_s2;
	logic [ADDR_W-1:0]     addr_s2;
	logic [PSUM_W-1:0]     pwr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			rd_s2  <= 1'b0;
			ok_s2  <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			rd_s2  <= rd_s1;
			ok_s2  <= ok_s1;
		end
	end

	always_ff @(posedge clk) begin
		dc_s2   <= (coarse_s1 == '0) && (chan_s1 == '0);
		zap_s2  <= !rd_s1 && cfg.zap_dc && (coarse_s1 == '0);
		ant_s2  <= FLAG_IDX_W'(ant_s1);
		addr_s2 <= addr_s1;
		pwr_s2  <= pwr_s1;
	end

	// last write, for the read-first RAM hazard one item back
	logic               wr_vld_q;
	logic [ADDR_W-1:0]  wr_addr_q;
	logic [POWER_W-1:0] wr_data_q;
	// per antenna: DC entry has been zapped, stored word is stale
	logic               zflag_q [NUM_ANTENNAS];

	logic [POWER_W-1:0] ram_rdata;
	logic [POWER_W-1:0] old_s2;
	logic [POWER_W:0]   sum_s2;
	logic [POWER_W-1:0] new_s2;
	logic               we_s2;
	logic [POWER_W-1:0] wdata_s2;

	always_comb begin
		if (!ok_s2 || (dc_s2 && zflag_q[ant_s2])) begin
			old_s2 = '0;
		end else if (wr_vld_q && (wr_addr_q == addr_s2)) begin
			old_s2 = wr_data_q;
		end else begin
			old_s2 = ram_rdata;
		end
	end

	assign sum_s2   = {1'b0, old_s2} + (POWER_W + 1)'(pwr_s2);
	assign new_s2   = sum_s2[POWER_W] ? ACC_MAX : sum_s2[POWER_W-1:0];
	assign we_s2    = vld_s2 && ok_s2;
	assign wdata_s2 = rd_s2 ? '0 : new_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
		end else begin
			wr_vld_q <= we_s2;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= addr_s2;
		wr_data_q <= wdata_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ANTENNAS; i++) begin
				zflag_q[i] <= 1'b0;
			end
		end else if (we_s2) begin
			if (zap_s2) begin
				zflag_q[ant_s2] <= 1'b1;
			end else if (dc_s2) begin
				zflag_q[ant_s2] <= 1'b0;
			end
		end
	end

	// ---------------- store ----------------
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [POWER_W-1:0] ram_wdata;

	assign ram_we    = clearing_q || we_s2;
	assign ram_waddr = clearing_q ? clr_q : addr_s2;
	assign ram_wdata = clearing_q ? '0 : wdata_s2;

	spa_ram #(
		.WIDTH (POWER_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_s1),
		.rdata (ram_rdata)
	);

	// ---------------- results ----------------
	out_item_t push_item;
	out_item_t head;

	assign push_item.power     = old_s2;
	assign push_item.saturated = (old_s2 == ACC_MAX);

	spa_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (vld_s2 && rd_s2),
		.push_item (push_item),
		.tvalid    (m_axis_tvalid),
		.tready    (m_axis_tready),
		.head      (head),
		.count     (fifo_cnt)
	);

	assign m_axis_tdata = head.power;
	assign m_axis_tuser = head.saturated;

	// ---------------- configuration ----------------
	spa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

endmodule

@@ rtl/core/spa_ram.sv @@
// ---------------------------------------------------------------------------
// spa_ram
// Generic single-write, single-read RAM, registered read, read-first.
// ---------------------------------------------------------------------------
module spa_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/spa_cfg.sv @@
// ---------------------------------------------------------------------------
// spa_cfg
// APB register file: sideband swap, DC zap, antenna selection.
// ---------------------------------------------------------------------------
module spa_cfg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [spa_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	output spa_pkg::cfg_t          cfg
);
	import spa_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dual_sideband  <= 1'b0;
			cfg_q.zap_dc         <= 1'b0;
			cfg_q.antenna_select <= 5'sb11111;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_DUAL_SIDEBAND:  cfg_q.dual_sideband  <= pwdata[0];
				REG_ZAP_DC:         cfg_q.zap_dc         <= pwdata[0];
				REG_ANTENNA_SELECT: cfg_q.antenna_select <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[1:0] == 2'b00) begin
			case (paddr[3:2])
				REG_DUAL_SIDEBAND:  prdata = {31'd0, cfg_q.dual_sideband};
				REG_ZAP_DC:         prdata = {31'd0, cfg_q.zap_dc};
				REG_ANTENNA_SELECT: prdata = {27'd0, cfg_q.antenna_select};
				default:            prdata = 32'd0;
			endcase
		end
	end

endmodule

@@ rtl/core/spa_out_fifo.sv @@
// ---------------------------------------------------------------------------
// spa_out_fifo
// Small result queue; upstream reserves space before issuing reads.
// ---------------------------------------------------------------------------
module spa_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  spa_pkg::out_item_t            push_item,
	output logic                          tvalid,
	input  logic                          tready,
	output spa_pkg::out_item_t            head,
	output logic [spa_pkg::OUT_CNT_W-1:0] count
);
	import spa_pkg::*;

	out_item_t             slot_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]  wr_ptr_q;
	logic [OUT_PTR_W-1:0]  rd_ptr_q;
	logic [OUT_CNT_W-1:0]  cnt_q;
	logic                  pop;

	assign tvalid = (cnt_q != '0);
	assign pop    = tvalid && tready;
	assign head   = slot_q[rd_ptr_q];
	assign count  = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + OUT_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - OUT_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
